### src/isqrt_pkg.sv
// Shared widths, constants and the per-stage data word of the square root pipeline.
package isqrt_pkg;

	localparam int NUM_W = 31;
	localparam int ROOT_W = 20;
	localparam int ITERATIONS = 4;

	// One restoring cell per quotient bit, then one guess update cell
	localparam int CELLS_PER_STEP = NUM_W + 1;
	localparam int STAGES = ITERATIONS * CELLS_PER_STEP;
	localparam int SUM_W = NUM_W + 1;

	localparam logic [ROOT_W-1:0] SEED_GUESS = ROOT_W'(1255);
	localparam logic [ROOT_W-1:0] ROOT_MAX = '1;
	localparam logic [ROOT_W-1:0] ROOT_ONE = ROOT_W'(1);

	// Data carried from cell to cell
	typedef struct packed {
		logic [NUM_W-1:0]  num;        // original operand, kept for every step
		logic [NUM_W-1:0]  dvd;        // dividend bits still to be shifted in
		logic [NUM_W-1:0]  quo;        // quotient bits produced so far
		logic [ROOT_W-1:0] rem;        // partial remainder, always below guess
		logic [ROOT_W-1:0] guess;      // current Newton guess, also the divisor
		logic              below_two;  // operand below two: pass it through
	} isqrt_word_t;

endpackage

### src/isqrt_div_cell.sv
// One restoring division cell: produces one quotient bit of num / guess per stage.
module isqrt_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 valid_i,
	input  isqrt_pkg::isqrt_word_t word_i,
	output logic                 valid_o,
	output isqrt_pkg::isqrt_word_t word_o
);

	logic                         valid_q;
	isqrt_pkg::isqrt_word_t       word_q;
	isqrt_pkg::isqrt_word_t       word_d;
	logic [isqrt_pkg::ROOT_W:0]   trial;
	logic [isqrt_pkg::ROOT_W:0]   diff;
	logic                         qbit;

	// Shift the next dividend bit into the remainder and try a subtract
	always_comb begin
		trial = {word_i.rem, word_i.dvd[isqrt_pkg::NUM_W-1]};
		diff = trial - {1'b0, word_i.guess};
		qbit = (trial >= {1'b0, word_i.guess});
		word_d = word_i;
		word_d.rem = qbit ? diff[isqrt_pkg::ROOT_W-1:0] : trial[isqrt_pkg::ROOT_W-1:0];
		word_d.quo = {word_i.quo[isqrt_pkg::NUM_W-2:0], qbit};
		word_d.dvd = {word_i.dvd[isqrt_pkg::NUM_W-2:0], 1'b0};
	end

	// Advance valid with the whole chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_i;
		end
	end

	// Hold payload while the chain is stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= word_d;
		end
	end

	assign valid_o = valid_q;
	assign word_o = word_q;

endmodule

### src/isqrt_upd_cell.sv
// Guess update cell: guess = (guess + quotient) / 2, then re-arm the divider fields.
module isqrt_upd_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 valid_i,
	input  isqrt_pkg::isqrt_word_t word_i,
	output logic                 valid_o,
	output isqrt_pkg::isqrt_word_t word_o
);

	logic                            valid_q;
	isqrt_pkg::isqrt_word_t          word_q;
	isqrt_pkg::isqrt_word_t          word_d;
	logic [isqrt_pkg::SUM_W-1:0]     sum;
	logic [isqrt_pkg::NUM_W-1:0]     half;

	// Average guess and quotient, keep the guess in range and nonzero
	always_comb begin
		sum = isqrt_pkg::SUM_W'(word_i.guess) + isqrt_pkg::SUM_W'(word_i.quo);
		half = sum[isqrt_pkg::SUM_W-1:1];
		word_d = word_i;
		if (half > isqrt_pkg::NUM_W'(isqrt_pkg::ROOT_MAX)) begin
			word_d.guess = isqrt_pkg::ROOT_MAX;
		end else if (half == '0) begin
			word_d.guess = isqrt_pkg::ROOT_ONE;
		end else begin
			word_d.guess = half[isqrt_pkg::ROOT_W-1:0];
		end
		word_d.dvd = word_i.num;
		word_d.quo = '0;
		word_d.rem = '0;
	end

	// Advance valid with the whole chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_i;
		end
	end

	// Hold payload while the chain is stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= word_d;
		end
	end

	assign valid_o = valid_q;
	assign word_o = word_q;

endmodule

### src/integer_sqrt_newton_four_step_unit.sv
// Top level: pipelined integer square root by four Newton-Raphson steps.
//
// Input channel: number with in_valid / in_stall; a transaction completes at a
// rising edge with in_valid high and in_stall low. Output channel: root with
// out_valid / out_stall, same rule. One root leaves for every number taken.
// Operands below two come back unchanged; all others start from a guess of
// 1255 and go through four steps of guess = (guess + number / guess) / 2.
// Each step is a row of 31 restoring division cells, one quotient bit per
// cell, followed by one update cell: 4 * 32 = 128 registered cells. The
// accepting edge loads the first cell; the item then moves one cell per
// advancing edge and appears on out_valid when it reaches the last cell.
// The last update cell is the output register. A new number is taken every
// cycle as long as the output side takes results; throughput is one item per
// cycle while out_stall is low, since every cell of the chain is a register.
// While a root waits under out_stall the whole cell chain holds its contents
// and in_stall is raised in the same cycle; it drops as soon as the waiting
// root is taken. Reset clears every valid bit in the chain, so out_valid is
// low after reset and any items in flight are dropped.
module integer_sqrt_newton_four_step_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [isqrt_pkg::NUM_W-1:0]   number,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [isqrt_pkg::ROOT_W-1:0]  root
);

	logic                   adv;
	logic                   v   [isqrt_pkg::STAGES+1];
	isqrt_pkg::isqrt_word_t w   [isqrt_pkg::STAGES+1];
	isqrt_pkg::isqrt_word_t last_w;

	// Move the chain unless a finished root is held by the receiver
	assign adv = !(v[isqrt_pkg::STAGES] && out_stall);
	assign in_stall = !adv;

	// Seed the first divider row from the incoming number
	assign v[0] = in_valid;
	assign w[0] = '{
		num:       number,
		dvd:       number,
		quo:       '0,
		rem:       '0,
		guess:     isqrt_pkg::SEED_GUESS,
		below_two: (number < isqrt_pkg::NUM_W'(2))
	};

	// Build the rows: bit cells then an update cell per step
	for (genvar s = 0; s < isqrt_pkg::ITERATIONS; s++) begin : g_step
		for (genvar c = 0; c < isqrt_pkg::CELLS_PER_STEP; c++) begin : g_cell
			localparam int IDX = s * isqrt_pkg::CELLS_PER_STEP + c;
			if (c < isqrt_pkg::NUM_W) begin : g_div
				isqrt_div_cell u_div (
					.clk     (clk),
					.arst_n  (arst_n),
					.adv     (adv),
					.valid_i (v[IDX]),
					.word_i  (w[IDX]),
					.valid_o (v[IDX+1]),
					.word_o  (w[IDX+1])
				);
			end else begin : g_upd
				isqrt_upd_cell u_upd (
					.clk     (clk),
					.arst_n  (arst_n),
					.adv     (adv),
					.valid_i (v[IDX]),
					.word_i  (w[IDX]),
					.valid_o (v[IDX+1]),
					.word_o  (w[IDX+1])
				);
			end
		end
	end

	// Drive the result from the last update cell
	assign last_w = w[isqrt_pkg::STAGES];
	assign out_valid = v[isqrt_pkg::STAGES];
	assign root = last_w.below_two ? last_w.num[isqrt_pkg::ROOT_W-1:0] : last_w.guess;

	// An item moves exactly one cell per advancing edge
	a_chain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v[isqrt_pkg::STAGES] == $past(v[isqrt_pkg::STAGES-1]))
		else $error("output valid did not follow the previous cell");

	// A held chain keeps its output valid
	a_chain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> v[isqrt_pkg::STAGES])
		else $error("stalled result was lost");

	// The guess never reaches zero
	a_guess_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_w.below_two |-> last_w.guess != '0)
		else $error("zero guess at output");

	// A zero root only comes from a zero operand
	a_zero_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root == '0 |-> last_w.below_two && last_w.num == '0)
		else $error("zero root for a nonzero operand");

	// Partial remainder stays below the divisor at the end of the first row
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v[isqrt_pkg::NUM_W] |-> w[isqrt_pkg::NUM_W].rem < w[isqrt_pkg::NUM_W].guess)
		else $error("division remainder out of range");

endmodule

### tb/isqrt_root_checker.sv
// Channel monitor that predicts every root and compares it with the one the unit returns.
module isqrt_root_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [isqrt_pkg::NUM_W-1:0]  number,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [isqrt_pkg::ROOT_W-1:0] root,
	output int                           mismatch_count,
	output int                           roots_pending
);

	logic [isqrt_pkg::ROOT_W-1:0] expected_roots[$];

	// Fixed count of Newton steps from a seed of 1255; operands below two pass through
	function automatic logic [isqrt_pkg::ROOT_W-1:0] newton_root_of(
		input logic [isqrt_pkg::NUM_W-1:0] n);
		logic [31:0] guess;
		logic [32:0] sum;
		if (n < 2) begin
			return isqrt_pkg::ROOT_W'(n);
		end
		guess = 32'(isqrt_pkg::SEED_GUESS);
		for (int step = 0; step < isqrt_pkg::ITERATIONS; step++) begin
			sum = 33'(guess) + 33'(32'(n) / guess);
			guess = sum[32:1];
			if (guess == 0) begin
				guess = 1;
			end
		end
		if (guess > 32'(isqrt_pkg::ROOT_MAX)) begin
			guess = 32'(isqrt_pkg::ROOT_MAX);
		end
		return guess[isqrt_pkg::ROOT_W-1:0];
	endfunction

	initial begin
		mismatch_count = 0;
		roots_pending = 0;
	end

	// Queue a prediction per accepted number, check each accepted root against the oldest
	always @(posedge clk) begin
		logic [isqrt_pkg::ROOT_W-1:0] want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_roots.push_back(newton_root_of(number));
			end
			if (out_valid && !out_stall) begin
				if (expected_roots.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: root %0d returned with no number outstanding",
							$time, root);
					end
				end else begin
					want = expected_roots.pop_front();
					if (root !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: root mismatch, expected %0d, got %0d",
								$time, want, root);
						end
					end
				end
			end
			roots_pending = expected_roots.size();
		end
	end

endmodule

### tb/tb.sv
// Top of the square root unit testbench: clock, reset, number and stall stimulus, verdict.
module tb;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [isqrt_pkg::NUM_W-1:0]  number;
	logic                         out_valid;
	logic                         out_stall;
	logic [isqrt_pkg::ROOT_W-1:0] root;
	int                           mismatch_count;
	int                           roots_pending;

	// Idle behavior of each side: 0 none, 1 light, 2 heavy
	int                           send_mode;
	int                           stall_mode;
	int                           stall_left;

	integer_sqrt_newton_four_step_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.number    (number),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.root      (root)
	);

	isqrt_root_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.number         (number),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.root           (root),
		.mismatch_count (mismatch_count),
		.roots_pending  (roots_pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap(input int mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == 0) begin
			return 0;
		end
		if (r < (mode == 2 ? 30 : 55)) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Operand mix: full range, tiny values, near squares, powers of two and their complements, near the seed, up to 65535
	function automatic logic [isqrt_pkg::NUM_W-1:0] pick_number();
		logic [31:0] k;
		logic [31:0] v;
		case ($urandom_range(0, 6))
			0, 1: v = $urandom() & 32'h7FFF_FFFF;
			2: v = $urandom_range(0, 15);
			3: begin
				k = $urandom_range(0, 46340);
				v = k * k + $urandom_range(0, 2);
				v = (v == 0) ? 0 : v - 1;
			end
			4: begin
				v = 32'd1 << $urandom_range(0, isqrt_pkg::NUM_W - 1);
				if ($urandom_range(0, 1) == 1) begin
					v = ~v & 32'h7FFF_FFFF;
				end
			end
			5: v = $urandom_range(1000, 3_000_000);
			default: v = $urandom_range(2, 65535);
		endcase
		return v[isqrt_pkg::NUM_W-1:0];
	endfunction

	// Offer one number and hold it until the unit takes it
	task automatic send_number(input logic [isqrt_pkg::NUM_W-1:0] n);
		in_valid <= 1'b1;
		number <= n;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Drop valid for a random number of cycles, or keep streaming
	task automatic pause_sender();
		int gap;
		gap = pick_gap(send_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Hold the sender until the unit has returned every outstanding root
	task automatic drain_roots();
		in_valid <= 1'b0;
		while (roots_pending != 0) begin
			@(negedge clk);
		end
	endtask

	// Receiver stall pattern, advanced on the falling edge
	always @(negedge clk) begin
		if (!arst_n || stall_mode == 0) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < (stall_mode == 2 ? 60 : 25));
			stall_left = pick_gap(2);
		end
	end

	// Run limit
	initial begin
		#8_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [isqrt_pkg::NUM_W-1:0] directed[$];
		directed = '{0, 1, 2, 3, 4, 5, 8, 9, 1254, 1255, 1256, 1574024, 1575025,
			1575026, 46340 * 46340, 46341 * 46341 - 1, 1 << 30, (1 << 30) - 1,
			31'h7FFF_FFFE, 31'h7FFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAA, 100, 65536};

		arst_n = 1'b0;
		in_valid = 1'b0;
		number = '0;
		send_mode = 1;
		stall_mode = 1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed operands: edges of the range, pass-through values, seed neighborhood
		foreach (directed[i]) begin
			send_number(directed[i]);
			pause_sender();
		end
		drain_roots();

		// Random operands, idle behavior changing every hundred transactions
		for (int i = 0; i < 700; i++) begin
			if (i % 100 == 0) begin
				send_mode = $urandom_range(0, 2);
				stall_mode = $urandom_range(0, 2);
			end
			if (i == 350) begin
				drain_roots();
			end
			send_number(pick_number());
			pause_sender();
		end

		// Wait out the pipeline, then a margin for stray results
		drain_roots();
		repeat (300) @(posedge clk);

		if (mismatch_count == 0 && roots_pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
